### design/delta_word_decoder_top_assert.svh
// Assertion macros for the checker file of the delta word decoder.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DELTA_WORD_DECODER_TOP_ASSERT_SVH
`define DELTA_WORD_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define DWD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("delta word decoder check failed");

// Next-cycle implication, off while in reset.
`define DWD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("delta word decoder check failed");

// Condition that must hold in the cycle right after a reset cycle.
`define DWD_ASSERT_AFTER_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("delta word decoder reset check failed");

`endif

### design/dwd_pkg.sv
package dwd_pkg;

  // Parser phase codes
  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_FIRST = 3'd1;
  localparam logic [2:0] PH_TAG   = 3'd2;
  localparam logic [2:0] PH_DELTA = 3'd3;
  localparam logic [2:0] PH_RAW   = 3'd4;

  // Tag byte that announces a 2-byte delta
  localparam logic [7:0] TAG_DELTA = 8'h01;

  // Byte index value reached after the last byte of each field.
  // An 8-byte word wraps the 3-bit index back to zero.
  localparam logic [2:0] COUNT_END = 3'd4;
  localparam logic [2:0] DELTA_END = 3'd2;
  localparam logic [2:0] WORD_END  = 3'd0;

  // Finished word handed from the parser to the result register
  typedef struct packed {
    logic        valid;
    logic [63:0] word;
    logic        last;
  } parse_res_t;

endpackage

### design/dwd_in_stage.sv
module dwd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  // Hold the registered byte while the result side is blocked
  assign in_stall = byte_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  // Payload register, loaded on every accepted request
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_data <= in_byte;
    end
  end

endmodule

### design/dwd_parser.sv
module dwd_parser import dwd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] byte_data,
  output parse_res_t res
);

  logic [2:0]  phase;
  logic [2:0]  byte_index;
  logic [31:0] words_left;
  logic [63:0] assembly_buffer;
  logic [63:0] previous_word;

  logic [2:0]  phase_next;
  logic [2:0]  byte_index_next;
  logic [31:0] words_left_next;
  logic [63:0] assembly_buffer_next;
  logic [63:0] previous_word_next;

  // Next-state and result logic for one byte
  always_comb begin
    logic [63:0] buf_base;
    logic [63:0] buf_in;
    logic [2:0]  idx_base;
    logic [2:0]  idx_inc;
    logic [63:0] word;
    logic        emit;
    logic [31:0] left_dec;

    phase_next           = phase;
    byte_index_next      = byte_index;
    words_left_next      = words_left;
    assembly_buffer_next = assembly_buffer;
    previous_word_next   = previous_word;
    word                 = assembly_buffer;
    emit                 = 1'b0;

    // An unused phase code restarts a count from scratch
    buf_base = ((phase == PH_COUNT) || (phase == PH_FIRST) || (phase == PH_TAG) ||
                (phase == PH_DELTA) || (phase == PH_RAW)) ? assembly_buffer : 64'd0;
    idx_base = ((phase == PH_COUNT) || (phase == PH_FIRST) || (phase == PH_TAG) ||
                (phase == PH_DELTA) || (phase == PH_RAW)) ? byte_index : 3'd0;

    // Little-endian byte placement
    buf_in  = buf_base | (64'(byte_data) << {idx_base, 3'b000});
    idx_inc = idx_base + 3'd1;

    unique case (phase)
      PH_FIRST, PH_RAW: begin
        assembly_buffer_next = buf_in;
        byte_index_next      = idx_inc;
        if (idx_inc == WORD_END) begin
          emit = 1'b1;
          word = buf_in;
        end
      end
      PH_TAG: begin
        assembly_buffer_next = 64'd0;
        byte_index_next      = 3'd0;
        phase_next           = (byte_data == TAG_DELTA) ? PH_DELTA : PH_RAW;
      end
      PH_DELTA: begin
        assembly_buffer_next = buf_in;
        byte_index_next      = idx_inc;
        if (idx_inc == DELTA_END) begin
          emit = 1'b1;
          // Sign-extended delta, sum wraps modulo 2^64
          word = previous_word + {{48{buf_in[15]}}, buf_in[15:0]};
        end
      end
      default: begin
        // Word count (also any unused phase code)
        phase_next           = PH_COUNT;
        assembly_buffer_next = buf_in;
        byte_index_next      = idx_inc;
        if (idx_inc == COUNT_END) begin
          byte_index_next      = 3'd0;
          words_left_next      = buf_in[31:0];
          assembly_buffer_next = 64'd0;
          phase_next           = (buf_in[31:0] == 32'd0) ? PH_COUNT : PH_FIRST;
        end
      end
    endcase

    // Word finished: count it down and pick the next phase
    left_dec = words_left - 32'd1;
    if (emit) begin
      previous_word_next   = word;
      words_left_next      = left_dec;
      assembly_buffer_next = 64'd0;
      byte_index_next      = 3'd0;
      phase_next           = (left_dec == 32'd0) ? PH_COUNT : PH_TAG;
    end

    res.valid = take && emit;
    res.word  = word;
    res.last  = (left_dec == 32'd0);
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COUNT;
      byte_index      <= 3'd0;
      words_left      <= 32'd0;
      assembly_buffer <= 64'd0;
      previous_word   <= 64'd0;
    end else if (take) begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      words_left      <= words_left_next;
      assembly_buffer <= assembly_buffer_next;
      previous_word   <= previous_word_next;
    end
  end

endmodule

### design/dwd_out_stage.sv
module dwd_out_stage import dwd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  parse_res_t  res,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] word_value,
  output logic        is_last
);

  // Result register is free when empty or being taken this cycle
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      word_value <= res.word;
      is_last    <= res.last;
    end
  end

endmodule

### design/delta_word_decoder_top.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+---------------------------------
// input    | in_valid / in_stall         | in_byte[7:0]
// output   | out_valid / out_stall       | word_value[63:0], is_last
//
// One byte is taken per clock unless a stalled result blocks the input; a
// word goes via the input register, then the parser into the result reg.
// Throughput is one byte a cycle when not stalled; the 64-bit delta add is
// the longest path. rst is synchronous, active high; the parser returns to
// reading a count. An output stall holds the result register and then the
// input register; in_stall rises only while a result waits and is stalled.
module delta_word_decoder_top import dwd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] word_value,
  output logic        is_last
);

  logic       advance;
  logic       byte_valid;
  logic [7:0] byte_data;
  parse_res_t res;

  dwd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  dwd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (byte_valid && advance),
    .byte_data (byte_data),
    .res       (res)
  );

  dwd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_value (word_value),
    .is_last    (is_last)
  );

endmodule

### design/dwd_checker.sv
`include "delta_word_decoder_top_assert.svh"

module dwd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] word_value,
  input logic        is_last
);

  // A stalled result stays put
  `DWD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(word_value) && $stable(is_last))

  // Input side only backs up behind a stalled result
  `DWD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // Both registers come out of reset empty
  `DWD_ASSERT_AFTER_RST(a_rst_empty, !out_valid && !in_stall)

endmodule

bind delta_word_decoder_top dwd_checker u_dwd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .word_value (word_value),
  .is_last    (is_last)
);

### test/delta_word_decoder_top_tb.sv
`timescale 1ns / 1ps

module delta_word_decoder_top_tb import dwd_pkg::*; ();

  typedef struct {
    logic [63:0] word;
    logic        last;
  } word_res_t;

  // One scripted byte; typed rows carry the word that must come out
  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    logic [63:0] word;
    logic        last;
  } script_row_t;

  localparam int SCRIPT_LEN   = 28;
  localparam int RANDOM_BYTES = 500;
  localparam int MAX_REPORTS  = 10;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] word_value;
  logic        is_last;

  // Shadow of the parser state
  logic [2:0]  ph;
  logic [2:0]  idx;
  logic [31:0] remaining;
  logic [63:0] acc;
  logic [63:0] prev_word;

  word_res_t   pending_words[$];
  word_res_t   head;
  int          error_count = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;

  // Directed frames: empty frame, then a three-word frame with an all-ones
  // first word, a +1 delta that wraps to zero, and an unknown tag before a raw word
  script_row_t script [SCRIPT_LEN] = '{
    '{8'h00, 1'b0, 64'h0, 1'b0},
    '{8'h00, 1'b0, 64'h0, 1'b0},
    '{8'h00, 1'b0, 64'h0, 1'b0},
    '{8'h00, 1'b0, 64'h0, 1'b0},
    '{8'h03, 1'b0, 64'h0, 1'b0},
    '{8'h00, 1'b0, 64'h0, 1'b0},
    '{8'h00, 1'b0, 64'h0, 1'b0},
    '{8'h00, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{TAG_DELTA, 1'b0, 64'h0, 1'b0},
    '{8'h01, 1'b0, 64'h0, 1'b0},
    '{8'h00, 1'b1, 64'h0, 1'b0},
    '{8'hFF, 1'b0, 64'h0, 1'b0},
    '{8'h01, 1'b0, 64'h0, 1'b0},
    '{8'h23, 1'b0, 64'h0, 1'b0},
    '{8'h45, 1'b0, 64'h0, 1'b0},
    '{8'h67, 1'b0, 64'h0, 1'b0},
    '{8'h89, 1'b0, 64'h0, 1'b0},
    '{8'hAB, 1'b0, 64'h0, 1'b0},
    '{8'hCD, 1'b0, 64'h0, 1'b0},
    '{8'hEF, 1'b1, 64'hEFCD_AB89_6745_2301, 1'b1}
  };

  delta_word_decoder_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_value (word_value),
    .is_last    (is_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shift one byte into the field under assembly; 1 when the field is full
  function automatic bit absorb_byte(input logic [7:0] b, input logic [2:0] end_idx);
    acc = acc | (64'(b) << {idx, 3'b000});
    idx = idx + 3'd1;
    if (idx == end_idx) begin
      idx = 3'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void finish_word(input logic [63:0] w, output word_res_t res);
    prev_word = w;
    remaining = remaining - 32'd1;
    res.word  = w;
    res.last  = (remaining == 32'd0);
    ph        = res.last ? PH_COUNT : PH_TAG;
    acc       = '0;
  endfunction

  // Advance the shadow parser by one byte
  function automatic void decode_byte(input logic [7:0] b, output bit hit,
                                      output word_res_t res);
    hit      = 1'b0;
    res.word = 64'h0;
    res.last = 1'b0;
    case (ph)
      PH_FIRST, PH_RAW: begin
        if (absorb_byte(b, WORD_END)) begin
          finish_word(acc, res);
          hit = 1'b1;
        end
      end
      PH_TAG: begin
        acc = '0;
        idx = '0;
        ph  = (b == TAG_DELTA) ? PH_DELTA : PH_RAW;
      end
      PH_DELTA: begin
        if (absorb_byte(b, DELTA_END)) begin
          // sign-extended delta, sum wraps at 64 bits
          finish_word(prev_word + {{48{acc[15]}}, acc[15:0]}, res);
          hit = 1'b1;
        end
      end
      default: begin
        if (ph != PH_COUNT) begin
          ph  = PH_COUNT;
          idx = '0;
          acc = '0;
        end
        if (absorb_byte(b, COUNT_END)) begin
          remaining = acc[31:0];
          acc       = '0;
          ph        = (remaining == 32'd0) ? PH_COUNT : PH_FIRST;
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_delta();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Any tag but the delta tag
  function automatic logic [7:0] pick_tag();
    logic [7:0] t;
    t = 8'($urandom);
    case ($urandom_range(0, 3))
      0: t = 8'h00;
      1: t = 8'hFF;
      2: t = 8'h02;
      default: ;
    endcase
    if (t == TAG_DELTA) t = 8'h80;
    return t;
  endfunction

  // Drive one request, wait until it is taken, then idle per the burst pattern
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input logic [63:0] tw = 64'h0, input logic tl = 1'b0);
    bit        hit;
    word_res_t res;
    int        gap;
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, hit, res);
    if (typed) begin
      res.word = tw;
      res.last = tl;
      pending_words.insert(pending_words.size(), res);
    end else if (hit) begin
      pending_words.insert(pending_words.size(), res);
    end
    bytes_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Build a well-formed frame; a cut frame stops early and is completed
  // by filler bytes until the parser expects a new count
  task automatic send_frame(input int n_words, input bit cut);
    logic [7:0]  fb[$];
    logic [15:0] d;
    int          len;
    for (int i = 0; i < 4; i++) fb.insert(fb.size(), 8'(n_words >> (8 * i)));
    if (n_words > 0) begin
      for (int i = 0; i < 8; i++) fb.insert(fb.size(), pick_byte());
      for (int k = 1; k < n_words; k++) begin
        if ($urandom_range(0, 99) < 65) begin
          d = pick_delta();
          fb.insert(fb.size(), TAG_DELTA);
          fb.insert(fb.size(), d[7:0]);
          fb.insert(fb.size(), d[15:8]);
        end else begin
          fb.insert(fb.size(), pick_tag());
          for (int i = 0; i < 8; i++) fb.insert(fb.size(), pick_byte());
        end
      end
    end
    len = fb.size();
    if (cut && len > 5) len = $urandom_range(5, len - 1);
    for (int i = 0; i < len; i++) send_byte(fb[i]);
    while (ph != PH_COUNT || idx != 3'd0)
      send_byte((ph == PH_TAG && $urandom_range(0, 1) == 0) ? TAG_DELTA : pick_byte());
  endtask

  // Receiver stall pattern: runs of a randomly chosen mode
  initial begin
    int mode;
    int run;
    out_stall = 1'b0;
    mode = 0;
    run  = 0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(4, 40);
      end
      run--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((run % 8) < 5);
      endcase
    end
  end

  // Compare each delivered word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("%t: unexpected word %h last %b", $time, word_value, is_last);
        error_count++;
      end else begin
        head = pending_words.pop_front();
        if (word_value !== head.word || is_last !== head.last) begin
          if (error_count < MAX_REPORTS)
            $display("%t: word exp %h got %h, last exp %b got %b", $time,
                     head.word, word_value, head.last, is_last);
          error_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int n;
    int drain;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    ph        = PH_COUNT;
    idx       = '0;
    remaining = '0;
    acc       = '0;
    prev_word = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send_byte(script[i].b, script[i].typed, script[i].word, script[i].last);

    // mostly whole frames, some cut short
    while (bytes_sent < SCRIPT_LEN + RANDOM_BYTES) begin
      if ($urandom_range(0, 6) == 0) begin
        send_frame($urandom_range(2, 6), 1'b1);
      end else begin
        case ($urandom_range(0, 9))
          0: n = 0;
          1: n = $urandom_range(10, 30);
          default: n = $urandom_range(1, 6);
        endcase
        send_frame(n, 1'b0);
      end
    end

    // trailing noise
    repeat (16) send_byte(8'($urandom));
    in_valid <= 1'b0;

    drain = 0;
    while (pending_words.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (pending_words.size() != 0)
      $display("%0d predicted words never came out", pending_words.size());
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/dwd_pkg.sv
design/dwd_in_stage.sv
design/dwd_parser.sv
design/dwd_out_stage.sv
design/delta_word_decoder_top.sv
design/dwd_checker.sv
test/delta_word_decoder_top_tb.sv
